### rtl/mpsp_pkg.sv
// Shared types for the packet stream parser: parse phases, byte roles,
// status codes, packet type codes, the parser state and the result record.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mpsp_pkg;

  typedef enum logic [12:0] {
    PH_HEADER  = 13'h0001,
    PH_LENGTH  = 13'h0002,
    PH_CA0     = 13'h0004,
    PH_CA1     = 13'h0008,
    PH_TLEN_HI = 13'h0010,
    PH_TLEN_LO = 13'h0020,
    PH_TOPIC   = 13'h0040,
    PH_ID_HI   = 13'h0080,
    PH_ID_LO   = 13'h0100,
    PH_PAYLOAD = 13'h0200,
    PH_SUBCODE = 13'h0400,
    PH_IGNORE  = 13'h0800,
    PH_FAULT   = 13'h1000
  } phase_t;

  typedef enum logic [3:0] {
    ROLE_HEADER      = 4'd0,
    ROLE_LENGTH      = 4'd1,
    ROLE_TOPIC_LEN   = 4'd2,
    ROLE_TOPIC       = 4'd3,
    ROLE_PACKET_ID   = 4'd4,
    ROLE_PAYLOAD     = 4'd5,
    ROLE_SUBACK_CODE = 4'd6,
    ROLE_CONNACK_FLG = 4'd7,
    ROLE_CONNACK_RC  = 4'd8,
    ROLE_IGNORED     = 4'd9,
    ROLE_DISCARD     = 4'd10
  } role_t;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_CONNACK_SHORT = 3'd1,
    ST_TOPIC_BAD     = 3'd2,
    ST_ILLEGAL_QOS   = 3'd3,
    ST_ID_MISSING    = 3'd4,
    ST_LEN_OVERLONG  = 3'd5
  } status_t;

  localparam logic [3:0] KIND_CONNACK  = 4'd2;
  localparam logic [3:0] KIND_PUBLISH  = 4'd3;
  localparam logic [3:0] KIND_PUBACK   = 4'd4;
  localparam logic [3:0] KIND_PUBREC   = 4'd5;
  localparam logic [3:0] KIND_PUBREL   = 4'd6;
  localparam logic [3:0] KIND_PUBCOMP  = 4'd7;
  localparam logic [3:0] KIND_SUBACK   = 4'd9;
  localparam logic [3:0] KIND_UNSUBACK = 4'd11;

  localparam logic [1:0] QOS_ILLEGAL = 2'd3;

  typedef struct packed {
    phase_t      phase;
    logic [3:0]  kind;
    logic [3:0]  flags;
    logic [27:0] length_accum;
    logic [2:0]  length_byte_count;
    logic [27:0] bytes_left;
    logic [15:0] topic_left;
    logic [15:0] ident;
    logic        session;
    logic [7:0]  code;
    status_t     error;
    logic        fault;
  } state_t;

  typedef struct packed {
    logic [7:0]  byte_value;
    role_t       role;
    logic [3:0]  kind;
    logic [3:0]  flags;
    logic [1:0]  qos;
    logic [15:0] ident;
    logic [27:0] body_length;
    logic        session;
    logic [7:0]  code;
    logic        pkt_end;
    status_t     status;
  } result_t;

endpackage

`default_nettype wire

### rtl/mpsp_step.sv
// Per-byte parse logic: next parser state and the tagged result for one byte.
// Purely combinational; uses mpsp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mpsp_step import mpsp_pkg::*; #(
  parameter int MAX_LENGTH_BYTES = 4
) (
  input  state_t     cur,
  input  logic [7:0] rx_byte,
  output state_t     nxt,
  output result_t    res
);

  localparam logic [2:0] MaxLen = 3'(MAX_LENGTH_BYTES);

  function automatic logic [1:0] qos_of(input logic [3:0] kind, input logic [3:0] flags);
    return (kind == KIND_PUBLISH) ? flags[2:1] : 2'd0;
  endfunction

  function automatic phase_t body_start(input logic [3:0] kind);
    phase_t ph;
    if (kind == KIND_CONNACK)
      ph = PH_CA0;
    else if (kind == KIND_PUBLISH)
      ph = PH_TLEN_HI;
    else if (kind inside {KIND_PUBACK, KIND_PUBREC, KIND_PUBREL, KIND_PUBCOMP,
                          KIND_SUBACK, KIND_UNSUBACK})
      ph = PH_ID_HI;
    else
      ph = PH_IGNORE;
    return ph;
  endfunction

  // Status reported at packet end: a recorded error wins, else the part cut short.
  function automatic status_t end_status(input phase_t ph, input status_t err);
    status_t s;
    if (err != ST_OK) begin
      s = err;
    end else begin
      case (ph)
        PH_CA0, PH_CA1:                      s = ST_CONNACK_SHORT;
        PH_TLEN_HI, PH_TLEN_LO, PH_TOPIC:    s = ST_TOPIC_BAD;
        PH_ID_HI, PH_ID_LO:                  s = ST_ID_MISSING;
        default:                             s = ST_OK;
      endcase
    end
    return s;
  endfunction

  logic [1:0]  cur_qos;
  phase_t      topic_done_phase;
  status_t     topic_done_err;
  logic [27:0] len_add;
  logic [27:0] accum_next;
  logic [2:0]  count_next;
  logic [15:0] tlen_full;
  logic [15:0] topic_dec;

  // Where parsing goes once the topic is complete
  always_comb begin
    cur_qos = qos_of(cur.kind, cur.flags);
    if (cur_qos == QOS_ILLEGAL) begin
      topic_done_phase = PH_IGNORE;
      topic_done_err   = (cur.error == ST_OK) ? ST_ILLEGAL_QOS : cur.error;
    end else begin
      topic_done_phase = (cur_qos != 2'd0) ? PH_ID_HI : PH_PAYLOAD;
      topic_done_err   = cur.error;
    end
  end

  // Varint digit placed at 7 bits per length byte
  always_comb begin
    case (cur.length_byte_count[1:0])
      2'd0:    len_add = {21'd0, rx_byte[6:0]};
      2'd1:    len_add = {14'd0, rx_byte[6:0], 7'd0};
      2'd2:    len_add = {7'd0, rx_byte[6:0], 14'd0};
      default: len_add = {rx_byte[6:0], 21'd0};
    endcase
    accum_next = cur.length_accum + len_add;
    count_next = cur.length_byte_count + 3'd1;
    tlen_full  = {cur.topic_left[15:8], rx_byte};
    topic_dec  = cur.topic_left - 16'd1;
  end

  role_t   role;
  logic    pkt_end;
  status_t status;
  phase_t  nx;

  always_comb begin
    nxt     = cur;
    role    = ROLE_IGNORED;
    pkt_end = 1'b0;
    status  = ST_OK;
    nx      = cur.phase;
    if (cur.fault || cur.phase == PH_FAULT) begin
      role   = ROLE_DISCARD;
      status = ST_LEN_OVERLONG;
    end else if (cur.phase == PH_HEADER) begin
      role                   = ROLE_HEADER;
      nxt.kind               = rx_byte[7:4];
      nxt.flags              = rx_byte[3:0];
      nxt.length_accum       = '0;
      nxt.length_byte_count  = '0;
      nxt.bytes_left         = '0;
      nxt.topic_left         = '0;
      nxt.ident              = '0;
      nxt.session            = 1'b0;
      nxt.code               = '0;
      nxt.error              = ST_OK;
      nxt.phase              = PH_LENGTH;
    end else if (cur.phase == PH_LENGTH) begin
      role                  = ROLE_LENGTH;
      nxt.length_accum      = accum_next;
      nxt.length_byte_count = count_next;
      if (rx_byte[7]) begin
        if (count_next >= MaxLen) begin
          nxt.fault = 1'b1;
          nxt.phase = PH_FAULT;
          pkt_end   = 1'b1;
          status    = ST_LEN_OVERLONG;
        end
      end else begin
        nxt.bytes_left = accum_next;
        if (accum_next == 28'd0) begin
          pkt_end   = 1'b1;
          status    = end_status(body_start(cur.kind), cur.error);
          nxt.phase = PH_HEADER;
        end else begin
          nxt.phase = body_start(cur.kind);
        end
      end
    end else begin
      case (cur.phase)
        PH_CA0: begin
          role        = ROLE_CONNACK_FLG;
          nxt.session = rx_byte[0];
          nx          = PH_CA1;
        end
        PH_CA1: begin
          role     = ROLE_CONNACK_RC;
          nxt.code = rx_byte;
          nx       = PH_IGNORE;
        end
        PH_TLEN_HI: begin
          role           = ROLE_TOPIC_LEN;
          nxt.topic_left = {rx_byte, 8'd0};
          nx             = PH_TLEN_LO;
        end
        PH_TLEN_LO: begin
          role           = ROLE_TOPIC_LEN;
          nxt.topic_left = tlen_full;
          if (tlen_full == 16'd0) begin
            nx        = topic_done_phase;
            nxt.error = topic_done_err;
          end else begin
            nx = PH_TOPIC;
          end
        end
        PH_TOPIC: begin
          role           = ROLE_TOPIC;
          nxt.topic_left = topic_dec;
          if (topic_dec == 16'd0) begin
            nx        = topic_done_phase;
            nxt.error = topic_done_err;
          end
        end
        PH_ID_HI: begin
          role      = ROLE_PACKET_ID;
          nxt.ident = {rx_byte, 8'd0};
          nx        = PH_ID_LO;
        end
        PH_ID_LO: begin
          role      = ROLE_PACKET_ID;
          nxt.ident = {cur.ident[15:8], rx_byte};
          if (cur.kind == KIND_PUBLISH)
            nx = PH_PAYLOAD;
          else if (cur.kind == KIND_SUBACK)
            nx = PH_SUBCODE;
          else
            nx = PH_IGNORE;
        end
        PH_PAYLOAD: role = ROLE_PAYLOAD;
        PH_SUBCODE: role = ROLE_SUBACK_CODE;
        default: begin
          role = ROLE_IGNORED;
          nx   = PH_IGNORE;
        end
      endcase
      if (cur.bytes_left <= 28'd1) begin
        nxt.bytes_left = '0;
        pkt_end        = 1'b1;
        status         = end_status(nx, nxt.error);
        nxt.phase      = PH_HEADER;
      end else begin
        nxt.bytes_left = cur.bytes_left - 28'd1;
        nxt.phase      = nx;
      end
    end
  end

  always_comb begin
    res.byte_value  = rx_byte;
    res.role        = role;
    res.kind        = nxt.kind;
    res.flags       = nxt.flags;
    res.qos         = qos_of(nxt.kind, nxt.flags);
    res.ident       = nxt.ident;
    res.body_length = nxt.length_accum;
    res.session     = nxt.session;
    res.code        = nxt.code;
    res.pkt_end     = pkt_end;
    res.status      = status;
  end

endmodule

`default_nettype wire

### rtl/mpsp_out_reg.sv
// Result register with valid/ready handshake; takes a new item whenever it
// is empty or its item is being taken. Uses mpsp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mpsp_out_reg import mpsp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t din,
  output logic    can_load,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t dout
);

  logic    valid;
  result_t data;

  assign can_load  = !valid || out_ready;
  assign out_valid = valid;
  assign dout      = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (can_load) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      data <= din;
    end
  end

endmodule

`default_nettype wire

### rtl/mqtt_packet_stream_parser_core.sv
// Top level of the MQTT 3.1.1 packet stream parser: parser state registers,
// per-byte step logic and the result register. Uses mpsp_pkg, mpsp_step,
// mpsp_out_reg.
//
// Usage:
//   Input channel (in_valid/in_ready, rx_byte) takes one received byte per
//   item. Output channel (out_valid/out_ready) returns one tagged result per
//   byte: the byte echoed, its role in the packet, the header type and flags,
//   QoS, packet id, decoded remaining length, CONNACK fields, packet_end and
//   status.
//   Latency: a result is valid the cycle after its byte is accepted.
//   Throughput: one byte per cycle while in_ready is high; the whole parse
//   of a byte is one pass through the step logic between the state registers
//   and the result register.
//   Stall: in_ready stays high while the result register is empty or being
//   drained; while the receiver holds out_ready low with a result waiting,
//   in_ready drops and nothing is lost.
//   Reset (rst, synchronous): parser waits for a header byte, all fields 0,
//   no result pending. An overlong length field is a sticky fault that only
//   reset clears; until then every byte is tagged discarded with status 5.
`timescale 1ns / 1ps
`default_nettype none

module mqtt_packet_stream_parser_core import mpsp_pkg::*; #(
  parameter int MAX_LENGTH_BYTES = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  byte_value,
  output logic [3:0]  byte_role,
  output logic [3:0]  packet_kind,
  output logic [3:0]  header_flags,
  output logic [1:0]  qos_level,
  output logic [15:0] ident,
  output logic [27:0] body_length,
  output logic        session_flag,
  output logic [7:0]  connect_code,
  output logic        packet_end,
  output logic [2:0]  status
);

  localparam state_t STATE_RESET = '{
    phase:             PH_HEADER,
    kind:              '0,
    flags:             '0,
    length_accum:      '0,
    length_byte_count: '0,
    bytes_left:        '0,
    topic_left:        '0,
    ident:             '0,
    session:           1'b0,
    code:              '0,
    error:             ST_OK,
    fault:             1'b0
  };

  state_t  state;
  state_t  state_next;
  result_t step_res;
  result_t out_res;
  logic    accept;

  assign accept = in_valid && in_ready;

  mpsp_step #(
    .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
  ) u_step (
    .cur    (state),
    .rx_byte(rx_byte),
    .nxt    (state_next),
    .res    (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (accept) begin
      state <= state_next;
    end
  end

  mpsp_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (in_valid),
    .din      (step_res),
    .can_load (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .dout     (out_res)
  );

  assign byte_value   = out_res.byte_value;
  assign byte_role    = out_res.role;
  assign packet_kind  = out_res.kind;
  assign header_flags = out_res.flags;
  assign qos_level    = out_res.qos;
  assign ident        = out_res.ident;
  assign body_length  = out_res.body_length;
  assign session_flag = out_res.session;
  assign connect_code = out_res.code;
  assign packet_end   = out_res.pkt_end;
  assign status       = out_res.status;

endmodule

`default_nettype wire

### rtl/mpsp_checker.sv
// Port-level checks for the packet stream parser, bound to the top level.
// Uses mpsp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mpsp_checker import mpsp_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  byte_value,
  input logic [3:0]  byte_role,
  input logic [3:0]  packet_kind,
  input logic [1:0]  qos_level,
  input logic [15:0] ident,
  input logic [27:0] body_length,
  input logic        packet_end,
  input logic [2:0]  status
);

  // A waiting result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(byte_value) && $stable(status))
    else $error("result changed while stalled");

  // Empty result register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty result register");

  // After a fault every byte is discarded with overlong status and no end
  a_discard: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_role == ROLE_DISCARD |-> status == ST_LEN_OVERLONG && !packet_end)
    else $error("discarded item with wrong status");

  // Status is only reported on packet end or in fault
  a_status_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && !packet_end && byte_role != ROLE_DISCARD |-> status == ST_OK)
    else $error("status outside packet end");

  // A header byte starts a fresh packet
  a_header_fresh: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_role == ROLE_HEADER |->
      ident == 16'd0 && body_length == 28'd0 && !packet_end &&
      (packet_kind == KIND_PUBLISH || qos_level == 2'd0))
    else $error("header item carries stale fields");

endmodule

bind mqtt_packet_stream_parser_core mpsp_checker u_mpsp_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .byte_value (byte_value),
  .byte_role  (byte_role),
  .packet_kind(packet_kind),
  .qos_level  (qos_level),
  .ident      (ident),
  .body_length(body_length),
  .packet_end (packet_end),
  .status     (status)
);

`default_nettype wire
